// ===== hdl/ptyld_pkg.sv =====
// Shared types and constants for the pseudo-terminal line discipline.
`timescale 1ns / 1ps
`default_nettype none

package ptyld_pkg;

    typedef logic [7:0] byte_t;

    typedef enum logic [1:0] {
        FN_MASTER_WRITE = 2'd0,
        FN_SLAVE_WRITE  = 2'd1,
        FN_SLAVE_READ   = 2'd2,
        FN_MASTER_READ  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        STS_OK    = 3'd0,
        STS_FULL  = 3'd1,
        STS_AGAIN = 3'd2,
        STS_EOF   = 3'd3,
        STS_ERR   = 3'd4
    } status_t;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CANONICAL  = 2'd0,
        CFG_ECHO       = 2'd1,
        CFG_MASTER_ATT = 2'd2,
        CFG_SLAVE_ATT  = 2'd3
    } cfg_idx_t;

    localparam byte_t CH_DEL = 8'h7f;
    localparam byte_t CH_CR  = 8'h0d;
    localparam byte_t CH_LF  = 8'h0a;
    localparam byte_t CH_BS  = 8'h08;
    localparam byte_t CH_SP  = 8'h20;

endpackage

`default_nettype wire

// ===== hdl/ptyld_ring_ram.sv =====
// Byte ring storage: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module ptyld_ring_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire                  aclk,
    input  wire                  wr_en,
    input  wire  [AW-1:0]        wr_addr,
    input  ptyld_pkg::byte_t     wr_data,
    input  wire                  rd_en,
    input  wire  [AW-1:0]        rd_addr,
    output ptyld_pkg::byte_t     rd_data
);
    import ptyld_pkg::*;

    byte_t mem [DEPTH];
    byte_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hdl/pty_line_discipline.sv =====
// Pseudo-terminal line discipline: request sequencer around two byte ring memories.
// A write or refused request gives its result in the cycle after acceptance;
// a read that returns a byte passes through the ring memory read register first.
// Requests are taken in idle only; a byte read adds a read state, an echoed write an echo
// state; an erase adds an erase-read state if the down ring is not empty, echo if echoed.
// Reset (aresetn low, synchronous) empties both rings and sets all four config bits to one.
`timescale 1ns / 1ps
`default_nettype none

module pty_line_discipline #(
    parameter int BUF_DEPTH = 256
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   cfg_wr_en,
    input  wire  [ptyld_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [0:0]                            cfg_data,
    input  wire                                   s_tvalid,
    output logic                                  s_tready,
    input  wire  [7:0]                            s_tdata,   // [7:0] data_in
    input  wire  [1:0]                            s_tuser,   // [1:0] func
    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    output logic [7:0]                            m_tdata,   // [7:0] data_out
    output logic [2:0]                            m_tuser,   // [2:0] status
    output logic                                  m_tlast    // line_end
);
    import ptyld_pkg::*;

    localparam int AW = $clog2(BUF_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(BUF_DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_DOWN,
        S_RD_UP,
        S_RD_ERASE,
        S_ECHO
    } state_t;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == LAST_IDX) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        return (p == '0) ? LAST_IDX : p - 1'b1;
    endfunction

    state_t        state_reg, state_next;
    logic [AW-1:0] dn_head_reg, dn_head_next;
    logic [AW-1:0] dn_tail_reg, dn_tail_next;
    logic [AW-1:0] dn_nl_reg, dn_nl_next;
    logic [AW-1:0] up_head_reg, up_head_next;
    logic [AW-1:0] up_tail_reg, up_tail_next;
    logic          canon_reg, canon_next;
    logic          echo_en_reg, echo_en_next;
    logic          master_att_reg, master_att_next;
    logic          slave_att_reg, slave_att_next;
    logic          m_valid_reg, m_valid_next;
    status_t       m_status_reg, m_status_next;
    byte_t         m_data_reg, m_data_next;
    logic          m_last_reg, m_last_next;
    logic          lend_reg, lend_next;
    logic          echo_erase_reg, echo_erase_next;
    byte_t         echo_data_reg, echo_data_next;
    logic [1:0]    echo_left_reg, echo_left_next;

    logic          dn_we, dn_re, up_we, up_re;
    logic [AW-1:0] dn_waddr, dn_raddr, up_waddr, up_raddr;
    byte_t         dn_wdata, up_wdata, dn_rdata, up_rdata;

    logic          accept;
    logic          out_load;
    func_t         func;
    byte_t         wbyte;
    logic          erase;
    logic          dn_empty, dn_full, up_empty, up_full;
    byte_t         echo_byte;
    logic [AW:0]   dn_used;

    ptyld_ring_ram #(.DEPTH(BUF_DEPTH), .AW(AW)) u_down_ram (
        .aclk    (aclk),
        .wr_en   (dn_we),
        .wr_addr (dn_waddr),
        .wr_data (dn_wdata),
        .rd_en   (dn_re),
        .rd_addr (dn_raddr),
        .rd_data (dn_rdata)
    );

    ptyld_ring_ram #(.DEPTH(BUF_DEPTH), .AW(AW)) u_up_ram (
        .aclk    (aclk),
        .wr_en   (up_we),
        .wr_addr (up_waddr),
        .wr_data (up_wdata),
        .rd_en   (up_re),
        .rd_addr (up_raddr),
        .rd_data (up_rdata)
    );

    assign func     = func_t'(s_tuser);
    assign s_tready = (state_reg == S_IDLE) && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    assign dn_empty = (dn_head_reg == dn_tail_reg);
    assign dn_full  = (ptr_inc(dn_head_reg) == dn_tail_reg);
    assign up_empty = (up_head_reg == up_tail_reg);
    assign up_full  = (ptr_inc(up_head_reg) == up_tail_reg);

    assign dn_used = (dn_head_reg >= dn_tail_reg)
                   ? ({1'b0, dn_head_reg} - {1'b0, dn_tail_reg})
                   : ({1'b0, dn_head_reg} + (AW+1)'(BUF_DEPTH) - {1'b0, dn_tail_reg});

    // canonical mapping of a master-written byte
    always_comb begin
        wbyte = s_tdata;
        if (canon_reg) begin
            if (wbyte == CH_CR) begin
                wbyte = CH_LF;
            end
            if (wbyte == CH_DEL) begin
                wbyte = CH_BS;
            end
        end
        erase = canon_reg && (wbyte == CH_BS);
    end

    // erase echoes BS SP BS; a plain echo sends the stored byte
    always_comb begin
        if (echo_erase_reg) begin
            echo_byte = (echo_left_reg == 2'd2) ? CH_SP : CH_BS;
        end else begin
            echo_byte = echo_data_reg;
        end
    end

    always_comb begin
        state_next      = state_reg;
        dn_head_next    = dn_head_reg;
        dn_tail_next    = dn_tail_reg;
        dn_nl_next      = dn_nl_reg;
        up_head_next    = up_head_reg;
        up_tail_next    = up_tail_reg;
        canon_next      = canon_reg;
        echo_en_next    = echo_en_reg;
        master_att_next = master_att_reg;
        slave_att_next  = slave_att_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_data_next     = m_data_reg;
        m_last_next     = m_last_reg;
        lend_next       = lend_reg;
        echo_erase_next = echo_erase_reg;
        echo_data_next  = echo_data_reg;
        echo_left_next  = echo_left_reg;
        out_load        = 1'b0;
        dn_we           = 1'b0;
        dn_re           = 1'b0;
        up_we           = 1'b0;
        up_re           = 1'b0;
        dn_waddr        = dn_head_reg;
        dn_wdata        = wbyte;
        dn_raddr        = dn_tail_reg;
        up_waddr        = up_head_reg;
        up_wdata        = s_tdata;
        up_raddr        = up_tail_reg;

        if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_CANONICAL:  canon_next      = cfg_data[0];
                CFG_ECHO:       echo_en_next    = cfg_data[0];
                CFG_MASTER_ATT: master_att_next = cfg_data[0];
                CFG_SLAVE_ATT:  slave_att_next  = cfg_data[0];
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    out_load      = 1'b1;
                    m_status_next = STS_OK;
                    m_data_next   = '0;
                    m_last_next   = 1'b0;
                    case (func)
                        FN_MASTER_WRITE: begin
                            if (!slave_att_reg) begin
                                m_status_next = STS_ERR;
                            end else if (erase) begin
                                echo_erase_next = 1'b1;
                                echo_left_next  = 2'd3;
                                if (!dn_empty) begin
                                    dn_re      = 1'b1;
                                    dn_raddr   = ptr_dec(dn_head_reg);
                                    state_next = S_RD_ERASE;
                                end else if (echo_en_reg) begin
                                    state_next = S_ECHO;
                                end
                            end else if (dn_full) begin
                                m_status_next = STS_FULL;
                            end else begin
                                dn_we        = 1'b1;
                                dn_head_next = ptr_inc(dn_head_reg);
                                if (wbyte == CH_LF) begin
                                    dn_nl_next = dn_nl_reg + 1'b1;
                                end
                                if (echo_en_reg) begin
                                    echo_erase_next = 1'b0;
                                    echo_data_next  = wbyte;
                                    echo_left_next  = 2'd1;
                                    state_next      = S_ECHO;
                                end
                            end
                        end
                        FN_SLAVE_WRITE: begin
                            if (!master_att_reg) begin
                                m_status_next = STS_ERR;
                            end else if (up_full) begin
                                m_status_next = STS_FULL;
                            end else begin
                                up_we        = 1'b1;
                                up_head_next = ptr_inc(up_head_reg);
                            end
                        end
                        FN_SLAVE_READ: begin
                            if (dn_empty) begin
                                m_status_next = master_att_reg ? STS_AGAIN : STS_EOF;
                            end else if (canon_reg && dn_nl_reg == '0 && master_att_reg) begin
                                m_status_next = STS_AGAIN;
                            end else begin
                                out_load     = 1'b0;
                                dn_re        = 1'b1;
                                dn_tail_next = ptr_inc(dn_tail_reg);
                                lend_next    = canon_reg;
                                state_next   = S_RD_DOWN;
                            end
                        end
                        FN_MASTER_READ: begin
                            if (up_empty) begin
                                m_status_next = slave_att_reg ? STS_AGAIN : STS_EOF;
                            end else begin
                                out_load     = 1'b0;
                                up_re        = 1'b1;
                                up_tail_next = ptr_inc(up_tail_reg);
                                state_next   = S_RD_UP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RD_DOWN: begin
                out_load      = 1'b1;
                m_status_next = STS_OK;
                m_data_next   = dn_rdata;
                m_last_next   = lend_reg && (dn_rdata == CH_LF);
                if (dn_rdata == CH_LF && dn_nl_reg != '0) begin
                    dn_nl_next = dn_nl_reg - 1'b1;
                end
                state_next = S_IDLE;
            end
            S_RD_UP: begin
                out_load      = 1'b1;
                m_status_next = STS_OK;
                m_data_next   = up_rdata;
                m_last_next   = 1'b0;
                state_next    = S_IDLE;
            end
            S_RD_ERASE: begin
                if (dn_rdata != CH_LF) begin
                    dn_head_next = ptr_dec(dn_head_reg);
                end
                state_next = echo_en_reg ? S_ECHO : S_IDLE;
            end
            S_ECHO: begin
                up_wdata = echo_byte;
                if (!up_full) begin
                    up_we        = 1'b1;
                    up_head_next = ptr_inc(up_head_reg);
                end
                echo_left_next = echo_left_reg - 1'b1;
                if (echo_left_reg == 2'd1) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        m_status_reg   <= m_status_next;
        m_data_reg     <= m_data_next;
        m_last_reg     <= m_last_next;
        lend_reg       <= lend_next;
        echo_erase_reg <= echo_erase_next;
        echo_data_reg  <= echo_data_next;
        echo_left_reg  <= echo_left_next;
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            dn_head_reg    <= '0;
            dn_tail_reg    <= '0;
            dn_nl_reg      <= '0;
            up_head_reg    <= '0;
            up_tail_reg    <= '0;
            canon_reg      <= 1'b1;
            echo_en_reg    <= 1'b1;
            master_att_reg <= 1'b1;
            slave_att_reg  <= 1'b1;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            dn_head_reg    <= dn_head_next;
            dn_tail_reg    <= dn_tail_next;
            dn_nl_reg      <= dn_nl_next;
            up_head_reg    <= up_head_next;
            up_tail_reg    <= up_tail_next;
            canon_reg      <= canon_next;
            echo_en_reg    <= echo_en_next;
            master_att_reg <= master_att_next;
            slave_att_reg  <= slave_att_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

    // newline count never exceeds the bytes queued, counting the byte being read out
    a_nl_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, dn_nl_reg} <= dn_used + (AW+1)'(state_reg == S_RD_DOWN))
        else $error("newline count exceeds down ring occupancy");

    // a new result is loaded only when the previous one is gone or leaving
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && m_valid_reg |-> m_tready)
        else $error("result register overwritten");

    // a ring read always produces its result the next cycle
    a_read_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RD_DOWN || state_reg == S_RD_UP) |=> m_valid_reg)
        else $error("read result missing");

    // echo sequencer never runs with nothing left to send
    a_echo_left: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_ECHO |-> echo_left_reg != 2'd0)
        else $error("echo sequencer ran empty");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for pty_line_discipline with a ring-level scoreboard.
`timescale 1ns / 1ps

import ptyld_pkg::*;

typedef struct packed {
    status_t status;
    byte_t   data;
    logic    line_end;
} reply_t;

class line_scoreboard #(int DEPTH = 256);
    localparam int DOWN = 0;
    localparam int UP   = 1;

    byte_t       ring[2][DEPTH];
    int unsigned wr_ptr[2];
    int unsigned rd_ptr[2];
    int unsigned down_lines;
    bit          canon_on;
    bit          echo_on;
    bit          master_open;
    bit          slave_open;
    reply_t      pending[$];
    int unsigned errors;
    int unsigned results_seen;

    function new();
        wr_ptr       = '{0, 0};
        rd_ptr       = '{0, 0};
        down_lines   = 0;
        canon_on     = 1'b1;
        echo_on      = 1'b1;
        master_open  = 1'b1;
        slave_open   = 1'b1;
        errors       = 0;
        results_seen = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, bit v);
        case (idx)
            CFG_CANONICAL:  canon_on    = v;
            CFG_ECHO:       echo_on     = v;
            CFG_MASTER_ATT: master_open = v;
            CFG_SLAVE_ATT:  slave_open  = v;
        endcase
    endfunction

    function bit push_byte(int r, byte_t b);
        int unsigned nx;
        nx = (wr_ptr[r] + 1) % DEPTH;
        if (nx == rd_ptr[r]) return 1'b0;
        ring[r][wr_ptr[r]] = b;
        wr_ptr[r] = nx;
        return 1'b1;
    endfunction

    function bit pop_byte(int r, output byte_t b);
        b = 8'h00;
        if (rd_ptr[r] == wr_ptr[r]) return 1'b0;
        b = ring[r][rd_ptr[r]];
        rd_ptr[r] = (rd_ptr[r] + 1) % DEPTH;
        return 1'b1;
    endfunction

    function int outstanding();
        return pending.size();
    endfunction

    function void note_request(func_t f, byte_t d);
        reply_t      r;
        byte_t       c;
        bit          erase;
        int unsigned last;
        r.status   = STS_OK;
        r.data     = 8'h00;
        r.line_end = 1'b0;
        case (f)
            FN_MASTER_WRITE: begin
                if (!slave_open) begin
                    r.status = STS_ERR;
                end else begin
                    c     = d;
                    erase = 1'b0;
                    if (canon_on) begin
                        if (c == CH_CR) c = CH_LF;
                        if (c == CH_DEL) c = CH_BS;
                        erase = (c == CH_BS);
                    end
                    if (erase) begin
                        last = (wr_ptr[DOWN] + DEPTH - 1) % DEPTH;
                        if (wr_ptr[DOWN] != rd_ptr[DOWN] && ring[DOWN][last] != CH_LF)
                            wr_ptr[DOWN] = last;
                        if (echo_on) begin
                            void'(push_byte(UP, CH_BS));
                            void'(push_byte(UP, CH_SP));
                            void'(push_byte(UP, CH_BS));
                        end
                    end else if (!push_byte(DOWN, c)) begin
                        r.status = STS_FULL;
                    end else begin
                        if (c == CH_LF) down_lines++;
                        if (echo_on) void'(push_byte(UP, c));
                    end
                end
            end
            FN_SLAVE_WRITE: begin
                if (!master_open) r.status = STS_ERR;
                else if (!push_byte(UP, d)) r.status = STS_FULL;
            end
            FN_SLAVE_READ: begin
                if (wr_ptr[DOWN] == rd_ptr[DOWN]) begin
                    r.status = master_open ? STS_AGAIN : STS_EOF;
                end else if (canon_on && down_lines == 0 && master_open) begin
                    r.status = STS_AGAIN;
                end else begin
                    void'(pop_byte(DOWN, r.data));
                    if (r.data == CH_LF) begin
                        if (down_lines != 0) down_lines--;
                        r.line_end = canon_on;
                    end
                end
            end
            default: begin
                if (!pop_byte(UP, r.data)) r.status = slave_open ? STS_AGAIN : STS_EOF;
            end
        endcase
        pending.push_back(r);
    endfunction

    task report_mismatch(string msg);
        errors++;
        if (errors <= 40) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_result(logic [2:0] st, logic [7:0] d, logic le);
        reply_t want;
        results_seen++;
        if (pending.size() == 0) begin
            report_mismatch($sformatf("unrequested result status %0d data %02h", st, d));
            return;
        end
        want = pending.pop_front();
        if (st !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", st, want.status));
        if (d !== want.data)
            report_mismatch($sformatf("data %02h, want %02h", d, want.data));
        if (le !== want.line_end)
            report_mismatch($sformatf("line_end %b, want %b", le, want.line_end));
    endtask
endclass

module tb_top;
    localparam int RING_DEPTH    = 256;
    localparam int NUM_PHASES    = 9;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_AFTER    = 100;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 250000;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [0:0]           cfg_data  = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = 8'h00;
    logic [1:0]           s_tuser   = 2'b00;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [7:0]           m_tdata;
    logic [2:0]           m_tuser;
    logic                 m_tlast;

    bit                          no_gaps = 1'b0;
    int unsigned                 cycles;
    line_scoreboard #(RING_DEPTH) sb;

    pty_line_discipline #(
        .BUF_DEPTH(RING_DEPTH)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic byte_t pick_byte();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) return CH_CR;
        if (roll < 15) return CH_LF;
        if (roll < 19) return CH_DEL;
        if (roll < 22) return CH_BS;
        if (roll < 62) return byte_t'($urandom_range(8'h21, 8'h7e));
        return byte_t'($urandom_range(0, 255));
    endfunction

    function automatic func_t pick_func(int unsigned w_mw, int unsigned w_sw,
                                        int unsigned w_sr, int unsigned w_mr);
        int unsigned roll;
        roll = $urandom_range(0, w_mw + w_sw + w_sr + w_mr - 1);
        if (roll < w_mw) return FN_MASTER_WRITE;
        roll -= w_mw;
        if (roll < w_sw) return FN_SLAVE_WRITE;
        roll -= w_sw;
        if (roll < w_sr) return FN_SLAVE_READ;
        return FN_MASTER_READ;
    endfunction

    // s_tvalid stays high between back-to-back requests; it drops only in a gap.
    task automatic send_request(input func_t f, input byte_t d);
        while (!no_gaps && $urandom_range(0, 99) < 35) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(f, d);
    endtask

    task automatic put_reg(input cfg_idx_t idx, input bit v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge aclk);
        sb.set_reg(idx, v);
    endtask

    task automatic write_config(input bit canon, input bit echo, input bit m_att,
                                input bit s_att);
        put_reg(CFG_CANONICAL, canon);
        put_reg(CFG_ECHO, echo);
        put_reg(CFG_MASTER_ATT, m_att);
        put_reg(CFG_SLAVE_ATT, s_att);
        cfg_wr_en <= 1'b0;
    endtask

    // echo bytes may still be going into the up ring after the last result
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int unsigned hold_left;
        bit          held;
        hold_left = 0;
        held      = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata, m_tlast);
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!held && sb.results_seen >= HOLD_AFTER) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else begin
                m_tready <= no_gaps || $urandom_range(0, 99) >= 35;
            end
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("FAIL pty_line_discipline");
        $finish;
    end

    initial begin
        sb = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // line editing with reset config: canonical, echo, both sides open
        send_request(FN_MASTER_WRITE, 8'h61);
        send_request(FN_MASTER_WRITE, CH_CR);
        send_request(FN_SLAVE_READ, 8'h00);
        send_request(FN_SLAVE_READ, 8'hff);
        send_request(FN_SLAVE_READ, 8'h00);
        send_request(FN_MASTER_WRITE, CH_DEL);
        send_request(FN_MASTER_WRITE, 8'hff);
        send_request(FN_MASTER_WRITE, CH_BS);
        send_request(FN_MASTER_WRITE, CH_LF);
        send_request(FN_MASTER_WRITE, CH_BS);
        send_request(FN_MASTER_WRITE, 8'h00);
        send_request(FN_SLAVE_READ, 8'h00);
        send_request(FN_SLAVE_READ, 8'h00);
        send_request(FN_SLAVE_WRITE, 8'h00);
        send_request(FN_SLAVE_WRITE, 8'hff);
        send_request(FN_MASTER_READ, 8'h00);
        send_request(FN_MASTER_READ, 8'hff);
        send_request(FN_MASTER_READ, 8'h00);
        drain();

        // both sides detached: partial line drains, then end of file
        write_config(1'b1, 1'b1, 1'b0, 1'b0);
        send_request(FN_SLAVE_READ, 8'h00);
        send_request(FN_SLAVE_READ, 8'h00);
        send_request(FN_SLAVE_WRITE, 8'h5a);
        send_request(FN_MASTER_WRITE, 8'h41);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            int unsigned n;
            int unsigned w_mw, w_sw, w_sr, w_mr;
            bit          c, e, ma, sa;
            w_mw = 30; w_sw = 20; w_sr = 25; w_mr = 25;
            n    = 180;
            case (p)
                0: begin
                    c = 1'b1; e = 1'b1; ma = 1'b1; sa = 1'b1;
                    n = 200;
                end
                1: begin
                    c = 1'b0; e = 1'b0; ma = 1'b0; sa = 1'b0;
                    n = 80;
                    w_mw = 25; w_sw = 25;
                end
                2: begin
                    // fill the down ring: few newlines reach the reader
                    c = 1'b1; e = 1'b0; ma = 1'b1; sa = 1'b1;
                    n = 320;
                    w_mw = 90; w_sw = 0; w_sr = 10; w_mr = 0;
                end
                3: begin
                    // fill the up ring
                    c = 1'b0; e = 1'b1; ma = 1'b1; sa = 1'b1;
                    n = 320;
                    w_mw = 20; w_sw = 70; w_sr = 0; w_mr = 10;
                end
                default: begin
                    c  = $urandom_range(0, 1);
                    e  = $urandom_range(0, 1);
                    ma = $urandom_range(0, 99) < 85;
                    sa = $urandom_range(0, 99) < 85;
                end
            endcase
            write_config(c, e, ma, sa);
            no_gaps = (p == 4);
            for (int i = 0; i < n; i++)
                send_request(pick_func(w_mw, w_sw, w_sr, w_mr), pick_byte());
            drain();
            no_gaps = 1'b0;
        end

        if (sb.errors == 0)
            $display("PASS pty_line_discipline");
        else
            $display("FAIL pty_line_discipline");
        $finish;
    end
endmodule
